>>> sv/can_rxq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// can_rxq_pkg
// shared types and constants of the can receive frame queue
// ----------------------------------------------------------------------------
package can_rxq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int MAX_LENGTH  = 8;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W    = 29;
  localparam int LEN_W   = 4;
  localparam int DATA_W  = 64;
  localparam int TS_W    = 32;
  localparam int STAT_W  = 32;
  localparam int NBYTES  = DATA_W / 8;

  localparam int LEN_REMOTE_BIT = 6;
  localparam int ID_EXT_BIT     = 3;
  localparam int FLAG_WARN_BIT  = 0;
  localparam int FLAG_BOFF_BIT  = 5;

  typedef enum logic [1:0] {
    KIND_FRAME  = 2'd0,
    KIND_POP    = 2'd1,
    KIND_FLAGS  = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_POPPED  = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_QUEUED  = 3'd2,
    ST_DROPPED = 3'd3,
    ST_REMOTE  = 3'd4,
    ST_FLAGS   = 3'd5,
    ST_IGNORED = 3'd6
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              extended;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] data;
    logic [TS_W-1:0]   stamp;
  } frame_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  typedef struct packed {
    logic       received;
    logic       dropped;
    logic       flags_valid;
    logic [7:0] flags;
  } stat_ctrl_t;

  typedef struct packed {
    logic              bus_off;
    logic [STAT_W-1:0] overflow_count;
    logic [STAT_W-1:0] bus_off_count;
    logic [STAT_W-1:0] warning_count;
    logic [STAT_W-1:0] received_count;
  } stat_t;

endpackage
`default_nettype wire

>>> sv/can_rxq_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// can_rxq_decode
// identifier decode, length clamp and payload masking of a received frame
// ----------------------------------------------------------------------------
module can_rxq_decode
  import can_rxq_pkg::*;
(
  input  wire logic [7:0]        id_high_byte,
  input  wire logic [7:0]        id_low_byte,
  input  wire logic [7:0]        ext_id_high_byte,
  input  wire logic [7:0]        ext_id_low_byte,
  input  wire logic [7:0]        length_byte,
  input  wire logic [DATA_W-1:0] data_bytes,
  input  wire logic [TS_W-1:0]   arrival_time,
  output frame_t                 frame,
  output logic                   remote
);

  logic [LEN_W-1:0] raw_len;
  logic [LEN_W-1:0] len;

  always_comb begin
    remote  = length_byte[LEN_REMOTE_BIT];
    raw_len = length_byte[LEN_W-1:0];
    len     = (raw_len > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : raw_len;

    frame.extended = id_low_byte[ID_EXT_BIT];
    if (id_low_byte[ID_EXT_BIT]) begin
      frame.id = {id_high_byte, id_low_byte[7:5], id_low_byte[1:0],
                  ext_id_high_byte, ext_id_low_byte};
    end else begin
      frame.id = {18'd0, id_high_byte, id_low_byte[7:5]};
    end
    frame.length = len;
    for (int i = 0; i < NBYTES; i++) begin
      frame.data[i*8 +: 8] = (LEN_W'(i) < len) ? data_bytes[i*8 +: 8] : 8'd0;
    end
    frame.stamp = arrival_time;
  end

endmodule
`default_nettype wire

>>> sv/can_rxq_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// can_rxq_fifo
// ring buffer of decoded frames with read and write pointers and fill count
// ----------------------------------------------------------------------------
module can_rxq_fifo
  import can_rxq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire fifo_ctrl_t ctrl,
  input  wire frame_t     wr_frame,
  output frame_t          rd_frame,
  output logic [CNT_W-1:0] count,
  output fifo_status_t    stat
);

  frame_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    stat.empty = (count == '0);
    stat.full  = (count == CNT_W'(QUEUE_DEPTH));
    rd_frame   = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_ptr] <= wr_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctrl.push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (ctrl.pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (ctrl.push && !ctrl.pop) begin
        count <= count + CNT_W'(1);
      end else if (ctrl.pop && !ctrl.push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.push && stat.full))
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.pop && stat.empty))
    else $error("pop from empty queue");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (ctrl.push && !ctrl.pop) |=> count == $past(count) + CNT_W'(1))
    else $error("push did not raise fill count");
`endif

endmodule
`default_nettype wire

>>> sv/can_rxq_stats.sv
`default_nettype none
// ----------------------------------------------------------------------------
// can_rxq_stats
// bus-off latch and wrapping receive, overflow, bus-off and warning counters
// ----------------------------------------------------------------------------
module can_rxq_stats
  import can_rxq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire stat_ctrl_t ctrl,
  output stat_t           stats
);

  logic overflow_inc;
  logic boff_rise;

  always_comb begin
    overflow_inc = ctrl.dropped || (ctrl.flags_valid && (ctrl.flags[7:6] != 2'b00));
    boff_rise    = ctrl.flags_valid && ctrl.flags[FLAG_BOFF_BIT] && !stats.bus_off;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stats <= '0;
    end else begin
      if (ctrl.flags_valid) begin
        stats.bus_off <= ctrl.flags[FLAG_BOFF_BIT];
      end
      if (boff_rise) begin
        stats.bus_off_count <= stats.bus_off_count + STAT_W'(1);
      end
      if (ctrl.flags_valid && ctrl.flags[FLAG_WARN_BIT]) begin
        stats.warning_count <= stats.warning_count + STAT_W'(1);
      end
      if (overflow_inc) begin
        stats.overflow_count <= stats.overflow_count + STAT_W'(1);
      end
      if (ctrl.received) begin
        stats.received_count <= stats.received_count + STAT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_drop_is_received: assert property (@(posedge clk) disable iff (rst)
    ctrl.dropped |-> ctrl.received)
    else $error("drop without receive");

  a_boff_count_on_rise: assert property (@(posedge clk) disable iff (rst)
    boff_rise |=> stats.bus_off && stats.bus_off_count == $past(stats.bus_off_count) + STAT_W'(1))
    else $error("bus-off rise not counted");

  a_frame_not_flags: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.received && ctrl.flags_valid))
    else $error("frame and flag sample in one transaction");
`endif

endmodule
`default_nettype wire

>>> sv/can_rx_frame_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// can_rx_frame_queue
// can receive queue with frame decode, eight-entry fifo and error statistics
// ----------------------------------------------------------------------------
// One transaction is accepted per clock while out_stall does not hold the
// result register: an input register captures the item, then decode, fifo
// update and counter update load the result register. The sustained rate of
// one item per cycle, when no stall holds it, is set by that fifo and counter
// update. Counter and fill level outputs show the state after the item in the
// result register. No clearing pass runs after reset.
module can_rx_frame_queue
  import can_rxq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        kind,
  input  wire logic [7:0]        id_high_byte,
  input  wire logic [7:0]        id_low_byte,
  input  wire logic [7:0]        ext_id_high_byte,
  input  wire logic [7:0]        ext_id_low_byte,
  input  wire logic [7:0]        length_byte,
  input  wire logic [DATA_W-1:0] data_bytes,
  input  wire logic [TS_W-1:0]   arrival_time,
  input  wire logic [7:0]        error_flags,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             status,
  output logic [ID_W-1:0]        frame_id,
  output logic                   frame_extended,
  output logic [LEN_W-1:0]       frame_length,
  output logic [DATA_W-1:0]      frame_data,
  output logic [TS_W-1:0]        frame_time,
  output logic [3:0]             queue_count,
  output logic                   bus_off,
  output logic [STAT_W-1:0]      overflow_count,
  output logic [STAT_W-1:0]      bus_off_count,
  output logic [STAT_W-1:0]      warning_count,
  output logic [STAT_W-1:0]      received_count
);

  logic              receive_enabled;
  logic              s1_valid;
  kind_t             s1_kind;
  logic [7:0]        s1_id_high;
  logic [7:0]        s1_id_low;
  logic [7:0]        s1_ext_high;
  logic [7:0]        s1_ext_low;
  logic [7:0]        s1_length;
  logic [DATA_W-1:0] s1_data;
  logic [TS_W-1:0]   s1_time;
  logic [7:0]        s1_flags;

  logic              advance;
  logic              go;
  frame_t            dec_frame;
  logic              dec_remote;
  frame_t            head_frame;
  logic [CNT_W-1:0]  fill;
  fifo_status_t      fifo_stat;
  fifo_ctrl_t        fifo_ctrl;
  stat_ctrl_t        stat_ctrl;
  stat_t             stats;
  status_t           status_next;
  frame_t            frame_next;

  assign advance  = !(out_valid && out_stall);
  assign go       = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  can_rxq_decode u_decode (
    .id_high_byte     (s1_id_high),
    .id_low_byte      (s1_id_low),
    .ext_id_high_byte (s1_ext_high),
    .ext_id_low_byte  (s1_ext_low),
    .length_byte      (s1_length),
    .data_bytes       (s1_data),
    .arrival_time     (s1_time),
    .frame            (dec_frame),
    .remote           (dec_remote)
  );

  can_rxq_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (fifo_ctrl),
    .wr_frame (dec_frame),
    .rd_frame (head_frame),
    .count    (fill),
    .stat     (fifo_stat)
  );

  can_rxq_stats u_stats (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (stat_ctrl),
    .stats (stats)
  );

  always_comb begin
    status_next           = ST_IGNORED;
    frame_next            = '0;
    fifo_ctrl             = '0;
    stat_ctrl             = '0;
    stat_ctrl.flags       = s1_flags;
    unique case (s1_kind)
      KIND_POP: begin
        if (fifo_stat.empty) begin
          status_next = ST_EMPTY;
        end else begin
          status_next   = ST_POPPED;
          frame_next    = head_frame;
          fifo_ctrl.pop = go;
        end
      end
      KIND_FRAME: begin
        if (receive_enabled) begin
          if (dec_remote) begin
            status_next = ST_REMOTE;
          end else begin
            stat_ctrl.received = go;
            if (fifo_stat.full) begin
              status_next       = ST_DROPPED;
              stat_ctrl.dropped = go;
            end else begin
              status_next    = ST_QUEUED;
              fifo_ctrl.push = go;
            end
          end
        end
      end
      KIND_FLAGS: begin
        if (receive_enabled) begin
          status_next           = ST_FLAGS;
          stat_ctrl.flags_valid = go;
        end
      end
      default: begin
        status_next = ST_IGNORED;
      end
    endcase
  end

  always_comb begin
    queue_count    = 4'(fill);
    bus_off        = stats.bus_off;
    overflow_count = stats.overflow_count;
    bus_off_count  = stats.bus_off_count;
    warning_count  = stats.warning_count;
    received_count = stats.received_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receive_enabled <= 1'b0;
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        receive_enabled <= cfg_data;
      end
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind     <= kind_t'(kind);
      s1_id_high  <= id_high_byte;
      s1_id_low   <= id_low_byte;
      s1_ext_high <= ext_id_high_byte;
      s1_ext_low  <= ext_id_low_byte;
      s1_length   <= length_byte;
      s1_data     <= data_bytes;
      s1_time     <= arrival_time;
      s1_flags    <= error_flags;
    end
    if (go) begin
      status         <= status_next;
      frame_id       <= frame_next.id;
      frame_extended <= frame_next.extended;
      frame_length   <= frame_next.length;
      frame_data     <= frame_next.data;
      frame_time     <= frame_next.stamp;
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_has_frame: assert property (@(posedge clk) disable iff (rst)
    (go && s1_kind == KIND_POP && !fifo_stat.empty) |=> status == ST_POPPED)
    else $error("pop of held frame not reported");

  a_disabled_ignores: assert property (@(posedge clk) disable iff (rst)
    (go && !receive_enabled && s1_kind != KIND_POP) |=> status == ST_IGNORED)
    else $error("item taken while receive disabled");

  a_push_only_on_go: assert property (@(posedge clk) disable iff (rst)
    (fifo_ctrl.push || fifo_ctrl.pop || stat_ctrl.received || stat_ctrl.flags_valid) |-> go)
    else $error("state update without a transaction");
`endif

endmodule
`default_nettype wire
